[design/kcl_pkg.sv]
// Package with shared types and constants for the keypad code lock.
package kcl_pkg;

  // Result event codes carried in event_res.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ADDED   = 3'd1,
    EV_CLEARED = 3'd2,
    EV_PASS    = 3'd3,
    EV_DENIED  = 3'd4,
    EV_BUSY    = 3'd5,
    EV_EXPIRED = 3'd6,
    EV_FULL    = 3'd7
  } event_e;

  // Item kinds on the func field.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_KEY  = 1'b1;

  // Key bytes with a special meaning.
  localparam logic [7:0] KEY_NONE = 8'h00;
  localparam logic [7:0] KEY_STAR = 8'h2A;
  localparam logic [7:0] KEY_HASH = 8'h23;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd3;

  // Configuration reset values; the reset code is "1234A".
  localparam logic [63:0] CODE_LOW_RST  = 64'd280048644657;
  localparam logic [63:0] CODE_HIGH_RST = 64'd0;
  localparam logic [4:0]  CODE_LEN_RST  = 5'd5;
  localparam logic [15:0] HOLD_RST      = 16'd3000;

  // Saturation value of the hold counter.
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // Current configuration as seen by the step logic.
  typedef struct packed {
    logic [127:0] code_chars;
    logic [4:0]   code_length;
    logic [15:0]  hold_ticks;
  } cfg_t;

  // One result item before it enters the output register.
  typedef struct packed {
    event_e     event_res;
    logic [4:0] entered_count;
    logic       showing_verdict;
  } res_t;

endpackage

[design/kcl_key_if.sv]
// Input channel interface carrying key and tick items.
interface kcl_key_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] key_code;

  modport source (output valid, output func, output key_code, input ready);
  modport sink (input valid, input func, input key_code, output ready);
endinterface

[design/kcl_res_if.sv]
// Output channel interface carrying result items.
interface kcl_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [4:0] entered_count;
  logic       showing_verdict;

  modport source (output valid, output event_res, output entered_count,
                  output showing_verdict, input ready);
  modport sink (input valid, input event_res, input entered_count,
                input showing_verdict, output ready);
endinterface

[design/kcl_cfg.sv]
// Configuration register file of the keypad code lock.
module kcl_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output kcl_pkg::cfg_t                  cfg_o
);
  import kcl_pkg::*;

  logic [63:0] code_low_q;
  logic [63:0] code_high_q;
  logic [4:0]  code_len_q;
  logic [15:0] hold_q;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_low_q  <= CODE_LOW_RST;
      code_high_q <= CODE_HIGH_RST;
      code_len_q  <= CODE_LEN_RST;
      hold_q      <= HOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CODE_LOW:  code_low_q  <= cfg_wdata_i;
        CFG_CODE_HIGH: code_high_q <= cfg_wdata_i;
        CFG_CODE_LEN:  code_len_q  <= cfg_wdata_i[4:0];
        CFG_HOLD:      hold_q      <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.code_chars  = {code_high_q, code_low_q};
  assign cfg_o.code_length = code_len_q;
  assign cfg_o.hold_ticks  = hold_q;

endmodule

[design/kcl_step.sv]
// Lock state and the combinational step logic for one item.
module kcl_step #(
  parameter int unsigned MAX_CHARS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_en_i,
  input  logic          func_i,
  input  logic [7:0]    key_code_i,
  input  kcl_pkg::cfg_t cfg_i,
  output kcl_pkg::res_t res_o
);
  import kcl_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHARS + 1);

  logic [7:0]    chars_q [MAX_CHARS];
  logic [CW-1:0] count_q, count_d;
  logic          verdict_q, verdict_d;
  logic [15:0]   elapsed_q, elapsed_d;
  logic [15:0]   elapsed_inc;
  logic          mismatch;
  logic          match;
  logic          append;
  event_e        ev;

  // Compare each stored character with the code character at its position.
  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < MAX_CHARS; i++) begin
      if ((CW'(i) < count_q) && (chars_q[i] != cfg_i.code_chars[8*i +: 8])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign match = !mismatch && (cfg_i.code_length == 5'(count_q))
                 && (cfg_i.code_length <= 5'(MAX_CHARS));

  assign elapsed_inc = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 16'd1 : elapsed_q;

  // Next state and event for the item at hand.
  always_comb begin
    count_d   = count_q;
    verdict_d = verdict_q;
    elapsed_d = elapsed_q;
    append    = 1'b0;
    ev        = EV_NONE;
    if (func_i == FUNC_TICK) begin
      if (verdict_q) begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= cfg_i.hold_ticks) begin
          verdict_d = 1'b0;
          elapsed_d = '0;
          count_d   = '0;
          ev        = EV_EXPIRED;
        end
      end
    end else if (key_code_i != KEY_NONE) begin
      if (verdict_q) begin
        ev = EV_BUSY;
      end else if (key_code_i == KEY_STAR) begin
        count_d = '0;
        ev      = EV_CLEARED;
      end else if (key_code_i == KEY_HASH) begin
        ev        = match ? EV_PASS : EV_DENIED;
        verdict_d = 1'b1;
        elapsed_d = '0;
      end else if (count_q < CW'(MAX_CHARS)) begin
        append  = 1'b1;
        count_d = count_q + CW'(1);
        ev      = EV_ADDED;
      end else begin
        ev = EV_FULL;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      verdict_q <= 1'b0;
      elapsed_q <= '0;
    end else if (step_en_i) begin
      count_q   <= count_d;
      verdict_q <= verdict_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Entry buffer; only positions below the count are ever compared.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (step_en_i && append && (count_q == CW'(i))) begin
        chars_q[i] <= key_code_i;
      end
    end
  end

  assign res_o.event_res       = ev;
  assign res_o.entered_count   = 5'(count_d);
  assign res_o.showing_verdict = verdict_d;

  // The buffer never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_CHARS))
    else $error("entry count above capacity");

  // A key never ends a running hold period.
  a_key_keeps_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && verdict_q && func_i == FUNC_KEY) |=> verdict_q)
    else $error("hold ended by a key");

  // Expiry leaves an empty buffer and no verdict.
  a_expire_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && ev == EV_EXPIRED) |=> (count_q == '0 && !verdict_q
                                         && elapsed_q == '0))
    else $error("expiry left state behind");

  // A verdict always starts the hold period.
  a_verdict_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && (ev == EV_PASS || ev == EV_DENIED)) |=> verdict_q)
    else $error("verdict without hold");

endmodule

[design/keypad_code_lock.sv]
// Top level of the keypad code lock: input register, step logic, output register.
// Keypad code lock. Each input item is a keypress or a one-millisecond tick and
// produces exactly one result item. The block takes one item per clock cycle
// while the output side is not stalled. An item is captured in the input
// register at the edge that accepts it. The combinational step logic writes its
// result into the output register once that register is free or being emptied,
// and the sink takes the result from the output register. The rate is set only
// by the output side: while a result waits in the output register and the sink
// is not ready, the item in the input register waits and input ready drops once
// both registers are full. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must do so only while no item is in
// flight, as the block itself does not enforce it.
module keypad_code_lock #(
  parameter int unsigned MAX_CHARS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  kcl_key_if.sink                        key_i,
  kcl_res_if.source                      res_o
);
  import kcl_pkg::*;

  cfg_t       cfg;
  res_t       step_res;
  logic       in_valid_q;
  logic       in_func_q;
  logic [7:0] in_key_q;
  logic       res_valid_q;
  res_t       res_q;
  logic       advance;
  logic       step_en;

  // The step runs when the output register is free or being emptied.
  assign advance      = !res_valid_q || res_o.ready;
  assign step_en      = in_valid_q && advance;
  assign key_i.ready  = !in_valid_q || advance;

  kcl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kcl_step #(
    .MAX_CHARS (MAX_CHARS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (step_en),
    .func_i     (in_func_q),
    .key_code_i (in_key_q),
    .cfg_i      (cfg),
    .res_o      (step_res)
  );

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (key_i.ready) begin
      in_valid_q <= key_i.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (key_i.ready && key_i.valid) begin
      in_func_q <= key_i.func;
      in_key_q  <= key_i.key_code;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step_en) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= step_res;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.event_res       = res_q.event_res;
  assign res_o.entered_count   = res_q.entered_count;
  assign res_o.showing_verdict = res_q.showing_verdict;

endmodule

[bench/tb_keypad_code_lock.sv]
// Self-checking testbench for the keypad code lock, with a built-in predictor and scoreboard.
`timescale 1ns / 100ps

module tb_keypad_code_lock;
  import kcl_pkg::*;

  localparam int MAX_CHARS = 16;
  localparam int LONG_HOLD = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 360;
  localparam int MAX_REPORTS = 100;

  // One input item as it sits in the pending queue.
  typedef struct packed {
    logic       func;
    logic [7:0] key_code;
  } key_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kcl_key_if key_bus ();
  kcl_res_if res_bus ();

  keypad_code_lock #(
    .MAX_CHARS(MAX_CHARS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .key_i      (key_bus),
    .res_o      (res_bus)
  );

  // Items waiting to be driven and results waiting to be seen.
  key_item_t pending_keys[$];
  res_t      expected_results[$];
  key_item_t next_item;
  res_t      want_res;
  int        queued_items = 0;
  int        error_count = 0;
  int        idle_cycles = 0;

  // Idling controls, set per phase.
  int sender_gap_pct = 0;
  int sink_stall_pct = 0;
  logic hold_request = 1'b0;
  logic hold_seen;
  int   hold_left;

  // Predictor copy of the lock state and its configuration.
  logic [7:0]   entry_buf[MAX_CHARS];
  logic [4:0]   entry_len;
  logic         verdict_on;
  logic [15:0]  tick_count;
  logic [127:0] code_word;
  logic [4:0]   code_len;
  logic [15:0]  hold_limit;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_entry();
    for (int i = 0; i < MAX_CHARS; i++) entry_buf[i] = 8'h00;
    entry_len = 5'd0;
  endfunction

  // Advance the predicted lock by one item and return the result it causes.
  function automatic res_t lock_step(input logic func, input logic [7:0] key);
    res_t   r;
    event_e ev;
    logic   matched;
    ev = EV_NONE;
    if (func == FUNC_TICK) begin
      if (verdict_on) begin
        if (tick_count != ELAPSED_MAX) tick_count = tick_count + 16'd1;
        if (tick_count >= hold_limit) begin
          verdict_on = 1'b0;
          tick_count = 16'd0;
          clear_entry();
          ev = EV_EXPIRED;
        end
      end
    end else if (key != KEY_NONE) begin
      if (verdict_on) begin
        ev = EV_BUSY;
      end else if (key == KEY_STAR) begin
        clear_entry();
        ev = EV_CLEARED;
      end else if (key == KEY_HASH) begin
        // Lengths must agree and every entered character must equal the code.
        matched = (code_len <= MAX_CHARS) && (code_len == entry_len);
        for (int i = 0; i < MAX_CHARS; i++)
          if (i < entry_len && entry_buf[i] != code_word[8*i +: 8]) matched = 1'b0;
        ev = matched ? EV_PASS : EV_DENIED;
        verdict_on = 1'b1;
        tick_count = 16'd0;
      end else if (entry_len < MAX_CHARS) begin
        entry_buf[entry_len[3:0]] = key;
        entry_len = entry_len + 5'd1;
        ev = EV_ADDED;
      end else begin
        ev = EV_FULL;
      end
    end
    r.event_res = ev;
    r.entered_count = entry_len;
    r.showing_verdict = verdict_on;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Driver: offers the next pending item and predicts each accepted one.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      key_bus.valid <= 1'b0;
      key_bus.func <= FUNC_TICK;
      key_bus.key_code <= KEY_NONE;
    end else begin
      if (key_bus.valid && key_bus.ready)
        expected_results.push_back(lock_step(key_bus.func, key_bus.key_code));
      if (!key_bus.valid || key_bus.ready) begin
        if (pending_keys.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
          next_item = pending_keys.pop_front();
          key_bus.valid <= 1'b1;
          key_bus.func <= next_item.func;
          key_bus.key_code <= next_item.key_code;
        end else begin
          key_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the result side, started by a toggle of hold_request.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_request != hold_seen) begin
      hold_seen <= hold_request;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want_res = expected_results.pop_front();
          if (res_bus.event_res !== want_res.event_res)
            report_mismatch($sformatf("event_res got %0d, expected %0d",
                                      res_bus.event_res, want_res.event_res));
          if (res_bus.entered_count !== want_res.entered_count)
            report_mismatch($sformatf("entered_count got %0d, expected %0d",
                                      res_bus.entered_count, want_res.entered_count));
          if (res_bus.showing_verdict !== want_res.showing_verdict)
            report_mismatch($sformatf("showing_verdict got %0d, expected %0d",
                                      res_bus.showing_verdict, want_res.showing_verdict));
        end
      end
      res_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((key_bus.valid && key_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_keypad_code_lock: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_item(input logic func, input logic [7:0] key);
    key_item_t it;
    it.func = func;
    it.key_code = key;
    pending_keys.push_back(it);
    queued_items++;
  endtask

  // A random key byte that is neither empty nor a command key.
  function automatic logic [7:0] plain_key();
    logic [7:0] k;
    do k = 8'($urandom_range(1, 255)); while (k == KEY_STAR || k == KEY_HASH);
    return k;
  endfunction

  // Wait until every item is accepted and every result has been checked.
  task automatic drain();
    while (pending_keys.size() != 0 || key_bus.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_CODE_LOW:  code_word[63:0] = data;
      CFG_CODE_HIGH: code_word[127:64] = data;
      CFG_CODE_LEN:  code_len = data[4:0];
      CFG_HOLD:      hold_limit = data[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Load a code of the given length; bytes past the length are random filler.
  task automatic load_code(input int len, input int hold);
    logic [127:0] word;
    for (int i = 0; i < 16; i++)
      word[8*i +: 8] = (i < len) ? plain_key() : 8'($urandom_range(255));
    write_cfg(CFG_CODE_LOW, word[63:0]);
    write_cfg(CFG_CODE_HIGH, word[127:64]);
    write_cfg(CFG_CODE_LEN, 64'(len));
    write_cfg(CFG_HOLD, 64'(hold));
  endtask

  // Ticks that run out the verdict, with stray keys dropped along the way.
  task automatic push_hold();
    for (int t = 0; t < hold_limit; t++) begin
      if ($urandom_range(4) == 0) push_item(FUNC_KEY, 8'($urandom_range(255)));
      push_item(FUNC_TICK, 8'($urandom_range(255)));
    end
    if ($urandom_range(3) == 0) push_item(FUNC_TICK, 8'($urandom_range(255)));
  endtask

  // One user interaction: mostly entry attempts, some clears and noise.
  task automatic push_session();
    int kind;
    int n;
    int pos;
    kind = $urandom_range(99);
    if (kind < 45) begin
      // Correct code, sometimes after a false start that is cleared.
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) push_item(FUNC_KEY, plain_key());
        push_item(FUNC_KEY, KEY_STAR);
      end
      for (int i = 0; i < 16 && i < code_len; i++) push_item(FUNC_KEY, code_word[8*i +: 8]);
      push_item(FUNC_KEY, KEY_HASH);
      push_hold();
    end else if (kind < 70) begin
      // Near miss: one character may be changed, the last one dropped, or one added.
      n = $urandom_range(2);
      pos = $urandom_range(15);
      for (int i = 0; i < 16 && i < code_len; i++)
        if (!(n == 1 && i == code_len - 1))
          push_item(FUNC_KEY, (n == 0 && i == pos) ? plain_key() : code_word[8*i +: 8]);
      if (n == 2) push_item(FUNC_KEY, plain_key());
      push_item(FUNC_KEY, KEY_HASH);
      push_hold();
    end else if (kind < 80) begin
      // Random entry that may overrun the buffer.
      n = $urandom_range(18);
      repeat (n) push_item(FUNC_KEY, plain_key());
      push_item(FUNC_KEY, KEY_HASH);
      push_hold();
    end else if (kind < 90) begin
      n = $urandom_range(1, 8);
      repeat (n) push_item(FUNC_KEY, plain_key());
      push_item(FUNC_KEY, KEY_STAR);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endtask

  task automatic random_phase(input int gap_pct, input int stall_pct, input logic pressure);
    int target;
    load_code($urandom_range(16), $urandom_range(1, 12));
    sender_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    if (pressure) begin
      @(posedge clk);
      hold_request <= ~hold_request;
    end
    target = queued_items + ITEMS_PER_PHASE;
    while (queued_items < target) push_session();
    drain();
  endtask

  initial begin
    key_bus.valid = 1'b0;
    key_bus.func = FUNC_TICK;
    key_bus.key_code = KEY_NONE;
    res_bus.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_CODE_LOW;
    cfg_wdata = '0;

    // Predictor starts from the reset configuration.
    code_word = {CODE_HIGH_RST, CODE_LOW_RST};
    code_len = CODE_LEN_RST;
    hold_limit = HOLD_RST;
    clear_entry();
    verdict_on = 1'b0;
    tick_count = 16'd0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset code: idle tick and empty key, then a correct entry.
    push_item(FUNC_TICK, 8'hFF);
    push_item(FUNC_KEY, KEY_NONE);
    for (int i = 0; i < 5; i++) push_item(FUNC_KEY, code_word[8*i +: 8]);
    push_item(FUNC_KEY, KEY_HASH);
    // Keys are dropped during the verdict, an empty key does nothing.
    push_item(FUNC_KEY, "x");
    push_item(FUNC_KEY, KEY_NONE);
    push_item(FUNC_TICK, 8'h00);
    drain();
    // The longest hold keeps the verdict; a hold of one then ends it.
    write_cfg(CFG_HOLD, 64'd65535);
    push_item(FUNC_TICK, 8'h00);
    drain();
    write_cfg(CFG_HOLD, 64'd1);
    push_item(FUNC_TICK, 8'h00);
    drain();

    // Full-length code, overflow of the buffer, clear and an empty attempt.
    load_code(16, 1);
    for (int i = 0; i < 16; i++) push_item(FUNC_KEY, code_word[8*i +: 8]);
    push_item(FUNC_KEY, "7");
    push_item(FUNC_KEY, KEY_HASH);
    push_item(FUNC_TICK, 8'h55);
    push_item(FUNC_KEY, 8'hFF);
    push_item(FUNC_KEY, KEY_STAR);
    push_item(FUNC_KEY, KEY_HASH);
    push_item(FUNC_TICK, 8'hAA);
    drain();

    // Empty code matches an empty entry; a code longer than the buffer never does.
    load_code(0, 1);
    push_item(FUNC_KEY, KEY_HASH);
    push_item(FUNC_TICK, 8'h00);
    push_item(FUNC_KEY, 8'h01);
    push_item(FUNC_KEY, KEY_HASH);
    push_item(FUNC_TICK, 8'h00);
    drain();
    write_cfg(CFG_CODE_LEN, 64'd20);
    push_item(FUNC_KEY, KEY_HASH);
    push_item(FUNC_TICK, 8'h00);
    drain();

    // Random phases under different idling patterns.
    random_phase(0, 0, 1'b1);
    random_phase(62, 0, 1'b0);
    random_phase(0, 62, 1'b0);
    random_phase(26, 26, 1'b0);

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_keypad_code_lock: clean");
    end else begin
      $display("tb_keypad_code_lock: errors");
    end
    $finish;
  end

endmodule
